FILE: src/lhp_pkg.sv
`timescale 1ns / 1ps

package lhp_pkg;

  localparam int DUR_W   = 31;
  localparam int CNT_W   = 32;
  localparam int TOTAL_W = 40;

  localparam logic [CNT_W-1:0]   COUNT_MAX = '1;
  localparam logic [CNT_W-1:0]   MIN_EMPTY = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_SAT = '1;

  typedef enum logic {
    ACT_RECORD   = 1'b0,
    ACT_SNAPSHOT = 1'b1
  } action_t;

  typedef struct packed {
    action_t     action;
    logic [3:0]  stage;
    logic [31:0] elapsed_us;
  } cmd_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] sample_count;
    logic [DUR_W-1:0]   p50_us;
    logic [DUR_W-1:0]   p95_us;
    logic [DUR_W-1:0]   min_us;
    logic [DUR_W-1:0]   max_us;
  } result_t;

  typedef struct packed {
    logic [DUR_W-1:0] max_us;
    logic [CNT_W-1:0] min_us;
  } stage_word_t;

  localparam stage_word_t STAGE_CLEAR = '{max_us: '0, min_us: MIN_EMPTY};

endpackage

FILE: src/lhp_ram.sv
`timescale 1ns / 1ps

module lhp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/lhp_bin.sv
`timescale 1ns / 1ps

module lhp_bin
  import lhp_pkg::*;
#(
  parameter int NUM_BUCKETS     = 256,
  parameter int BUCKET_WIDTH_US = 500,
  localparam int BIDX_W = $clog2(NUM_BUCKETS)
) (
  input  logic              clk,
  input  logic              load,
  input  logic [DUR_W-1:0]  d,
  output logic [BIDX_W-1:0] bucket
);

  localparam int          FL2    = $clog2(BUCKET_WIDTH_US + 1) - 1;
  localparam int          SHIFT  = 31 + FL2;
  localparam logic [31:0] RECIP  = 32'((64'd1 << SHIFT) / BUCKET_WIDTH_US);
  localparam logic [31:0] BW32   = 32'(BUCKET_WIDTH_US);
  localparam logic [63:0] LIMIT  = 64'(NUM_BUCKETS) * 64'(BUCKET_WIDTH_US);
  localparam logic [BIDX_W-1:0] LAST = BIDX_W'(NUM_BUCKETS - 1);

  logic [DUR_W-1:0]  d1;
  logic              ovf1;
  logic [62:0]       prod1;
  logic [BIDX_W-1:0] qe_c;
  logic [BIDX_W-1:0] q_est;
  logic [31:0]       qbw;
  logic [31:0]       rem_c;

  assign qe_c  = prod1[SHIFT +: BIDX_W];
  assign rem_c = {1'b0, d1} - qbw;

  always_ff @(posedge clk) begin
    if (load) begin
      d1    <= d;
      ovf1  <= (64'(d) >= LIMIT);
      prod1 <= d * RECIP;
    end
    q_est <= qe_c;
    qbw   <= 32'(qe_c) * BW32;
  end

  // estimate is low by at most one
  always_comb begin
    if (ovf1) begin
      bucket = LAST;
    end else if (rem_c >= BW32) begin
      bucket = q_est + 1'b1;
    end else begin
      bucket = q_est;
    end
  end

endmodule

FILE: src/latency_histogram_percentiles_core.sv
`timescale 1ns / 1ps

// Per-stage latency histograms with snapshot percentiles.
// Input channel: cmd is taken at a rising edge where start is high and busy
// is low. A record (action 0) adds one duration to the bucket RAM of a stage
// and updates that stage's min and max; it gives no result. A snapshot
// (action 1) sums, scans and clears the stage and returns one result.
// Output channel: result is valid for exactly one cycle while done is high;
// the receiver cannot stall it and must take it in that cycle.
// A record passes through S_DIV (bucket index by reciprocal
// multiply), S_FIX (RAM read) and S_UPD (RAM write back). A snapshot
// makes two sweeps of the bucket RAM, one read per cycle, plus pipeline
// drain; done rises once the drain ends, in a cycle where the next
// command can already be taken. A snapshot of a stage at or above NUM_STAGES
// returns all zeros in the cycle after it is taken.
// Reset: a clearing pass writes every bucket word and every stage min/max
// entry with busy held high.
module latency_histogram_percentiles_core
  import lhp_pkg::*;
#(
  parameter int NUM_STAGES      = 16,
  parameter int NUM_BUCKETS     = 256,
  parameter int BUCKET_WIDTH_US = 500
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    done,
  output result_t result
);

  localparam int DEPTH  = NUM_STAGES * NUM_BUCKETS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int BIDX_W = $clog2(NUM_BUCKETS);
  localparam int SIDX_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
  localparam int SUM_W  = CNT_W + BIDX_W;
  localparam int PCT_W  = SUM_W + 7;
  localparam logic [63:0] EDGE_MAX = 64'(NUM_BUCKETS) * 64'(BUCKET_WIDTH_US);
  localparam int EDGE_W = $clog2(EDGE_MAX + 64'd1);
  localparam logic [EDGE_W-1:0] BW_E     = EDGE_W'(BUCKET_WIDTH_US);
  localparam logic [BIDX_W-1:0] K_LAST   = BIDX_W'(NUM_BUCKETS - 1);
  localparam logic [ADDR_W-1:0] A_LAST   = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] A_STAGES = ADDR_W'(NUM_STAGES);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DIV,
    S_FIX,
    S_UPD,
    S_SUM,
    S_SCAN,
    S_DRAIN
  } state_t;

  state_t state, state_next;

  logic              accept;
  logic              stage_ok;
  logic [DUR_W-1:0]  d_c;
  logic              drain_done;

  logic [SIDX_W-1:0] stg;
  logic [ADDR_W-1:0] base;
  logic [DUR_W-1:0]  dur;
  logic [BIDX_W-1:0] k;
  logic [ADDR_W-1:0] init_cnt;
  logic [BIDX_W-1:0] bucket;

  logic              bkt_we, bkt_re;
  logic [ADDR_W-1:0] bkt_waddr, bkt_raddr;
  logic [CNT_W-1:0]  bkt_wdata, bkt_rdata;

  logic              st_we;
  logic [SIDX_W-1:0] st_waddr;
  stage_word_t       st_wdata, st_rdata;

  logic              d1_vld, d1_scan;
  logic [ADDR_W-1:0] d1_addr;
  logic              c_vld;
  logic [SUM_W-1:0]  total, cum;
  logic [PCT_W-1:0]  t95x, cum100_c;
  logic [EDGE_W-1:0] bkt_edge, p50e, p95e;
  logic              have50, have95;
  logic              hit50_c, hit95_c;

  result_t           res_c;
  logic [DUR_W-1:0]  p95_c;
  logic [63:0]       tot64;

  assign accept   = start && !busy;
  assign stage_ok = (32'(cmd.stage) < NUM_STAGES);
  assign d_c      = cmd.elapsed_us[31] ? '0 : cmd.elapsed_us[DUR_W-1:0];
  assign drain_done = (state == S_DRAIN) && !d1_vld && !c_vld;

  lhp_bin #(
    .NUM_BUCKETS     (NUM_BUCKETS),
    .BUCKET_WIDTH_US (BUCKET_WIDTH_US)
  ) u_bin (
    .clk    (clk),
    .load   (accept),
    .d      (d_c),
    .bucket (bucket)
  );

  always_comb begin
    bkt_re    = (state == S_FIX) || (state == S_SUM) || (state == S_SCAN);
    bkt_raddr = (state == S_FIX) ? base + ADDR_W'(bucket) : base + ADDR_W'(k);
    if (state == S_INIT) begin
      bkt_we    = 1'b1;
      bkt_waddr = init_cnt;
      bkt_wdata = '0;
    end else if (state == S_UPD) begin
      bkt_we    = 1'b1;
      bkt_waddr = d1_addr;
      bkt_wdata = (bkt_rdata == COUNT_MAX) ? bkt_rdata : bkt_rdata + 1'b1;
    end else begin
      bkt_we    = d1_vld && d1_scan;
      bkt_waddr = d1_addr;
      bkt_wdata = '0;
    end
  end

  lhp_ram #(
    .WIDTH (CNT_W),
    .DEPTH (DEPTH)
  ) u_bkt_ram (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (bkt_waddr),
    .wdata (bkt_wdata),
    .re    (bkt_re),
    .raddr (bkt_raddr),
    .rdata (bkt_rdata)
  );

  always_comb begin
    st_we    = 1'b0;
    st_waddr = stg;
    st_wdata = STAGE_CLEAR;
    if (state == S_INIT) begin
      st_we    = (init_cnt < A_STAGES);
      st_waddr = SIDX_W'(init_cnt);
    end else if (state == S_UPD) begin
      st_we           = 1'b1;
      st_wdata.max_us = (dur > st_rdata.max_us) ? dur : st_rdata.max_us;
      st_wdata.min_us = ({1'b0, dur} < st_rdata.min_us) ? {1'b0, dur} : st_rdata.min_us;
    end else if (drain_done) begin
      st_we = 1'b1;
    end
  end

  lhp_ram #(
    .WIDTH ($bits(stage_word_t)),
    .DEPTH (NUM_STAGES)
  ) u_stage_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (1'b1),
    .raddr (stg),
    .rdata (st_rdata)
  );

  assign cum100_c = (PCT_W'(cum) << 6) + (PCT_W'(cum) << 5) + (PCT_W'(cum) << 2);
  assign hit50_c  = c_vld && !have50 && ({cum, 1'b0} > {1'b0, total});
  assign hit95_c  = c_vld && !have95 && (cum100_c > t95x);

  always_ff @(posedge clk) begin
    if (accept) begin
      stg      <= SIDX_W'(cmd.stage);
      base     <= ADDR_W'(cmd.stage) * ADDR_W'(NUM_BUCKETS);
      dur      <= d_c;
      total    <= '0;
      cum      <= '0;
      bkt_edge <= BW_E;
    end else begin
      if (d1_vld && !d1_scan) begin
        total <= total + SUM_W'(bkt_rdata);
      end
      if (d1_vld && d1_scan) begin
        cum <= cum + SUM_W'(bkt_rdata);
      end
      if (c_vld) begin
        bkt_edge <= bkt_edge + BW_E;
      end
    end
    if (hit50_c) begin
      p50e <= bkt_edge;
    end
    if (hit95_c) begin
      p95e <= bkt_edge;
    end
    t95x    <= (PCT_W'(total) << 7) - (PCT_W'(total) << 5) - PCT_W'(total);
    d1_addr <= bkt_raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_vld   <= 1'b0;
      d1_scan  <= 1'b0;
      c_vld    <= 1'b0;
      have50   <= 1'b0;
      have95   <= 1'b0;
      k        <= '0;
      init_cnt <= '0;
    end else begin
      d1_vld  <= (state == S_SUM) || (state == S_SCAN);
      d1_scan <= (state == S_SCAN);
      c_vld   <= d1_vld && d1_scan;
      if (accept) begin
        have50 <= 1'b0;
        have95 <= 1'b0;
      end else begin
        have50 <= have50 || hit50_c;
        have95 <= have95 || hit95_c;
      end
      if (state == S_INIT) begin
        init_cnt <= init_cnt + 1'b1;
      end
      if (accept) begin
        k <= '0;
      end else if ((state == S_SUM) || (state == S_SCAN)) begin
        k <= (k == K_LAST) ? '0 : k + 1'b1;
      end
    end
  end

  assign tot64 = 64'(total);

  always_comb begin
    p95_c = (64'(p95e) > 64'(st_rdata.max_us)) ? st_rdata.max_us : DUR_W'(p95e);
    res_c.sample_count = (tot64 > 64'(TOTAL_SAT)) ? TOTAL_SAT : tot64[TOTAL_W-1:0];
    res_c.max_us = st_rdata.max_us;
    res_c.min_us = (st_rdata.min_us == MIN_EMPTY) ? '0 : st_rdata.min_us[DUR_W-1:0];
    if (total == '0) begin
      res_c.p95_us = '0;
      res_c.p50_us = '0;
    end else begin
      res_c.p95_us = p95_c;
      res_c.p50_us = (64'(p50e) > 64'(p95_c)) ? p95_c : DUR_W'(p50e);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (init_cnt == A_LAST) state_next = S_IDLE;
      end
      S_IDLE, S_UPD: begin
        if (accept && stage_ok) begin
          state_next = (cmd.action == ACT_SNAPSHOT) ? S_SUM : S_DIV;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIV:   state_next = S_FIX;
      S_FIX:   state_next = S_UPD;
      S_SUM: begin
        if (k == K_LAST) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (k == K_LAST) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (drain_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= !((state_next == S_IDLE) || (state_next == S_UPD));
      done  <= drain_done || (accept && (cmd.action == ACT_SNAPSHOT) && !stage_ok);
      if (drain_done) begin
        result <= res_c;
      end else if (accept) begin
        result <= '0;
      end
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_record_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && stage_ok && (cmd.action == ACT_RECORD)) |=> busy)
    else $error("record transaction not held off");

  a_rw_split: assert property (@(posedge clk) disable iff (rst)
    (bkt_we && bkt_re) |-> (bkt_waddr != bkt_raddr))
    else $error("bucket read and write hit the same word");

  a_p95_after_p50: assert property (@(posedge clk) disable iff (rst)
    have95 |-> have50)
    else $error("p95 found before p50");

  a_scan_pipe: assert property (@(posedge clk) disable iff (rst)
    c_vld |-> ((state == S_SCAN) || (state == S_DRAIN)))
    else $error("scan pipeline active outside snapshot");

endmodule
